/* sv/hpd_pkg.sv */
// Shared types, field widths and codes for the HPACK dynamic table.
// Used by hpd_front, hpd_back and hpack_dynamic_table; depends on nothing.
`default_nettype none

package hpd_pkg;

	// Field widths of the stream payloads
	localparam int FUNC_W   = 2;
	localparam int SIZE_W   = 13;
	localparam int HANDLE_W = 32;
	localparam int IDX_W    = 8;
	localparam int NCAP_W   = 13;
	localparam int STATUS_W = 2;
	localparam int EVICT_W  = 8;
	localparam int COUNT_W  = 8;
	localparam int BYTES_W  = 13;

	localparam int IN_DATA_RAW  = SIZE_W + HANDLE_W + IDX_W + NCAP_W;
	localparam int IN_DATA_W    = ((IN_DATA_RAW + 7) / 8) * 8;
	localparam int IN_USER_W    = FUNC_W;
	localparam int OUT_DATA_RAW = HANDLE_W + SIZE_W + EVICT_W + COUNT_W + BYTES_W;
	localparam int OUT_DATA_W   = ((OUT_DATA_RAW + 7) / 8) * 8;
	localparam int OUT_USER_W   = STATUS_W;

	// Table limits
	localparam int DEF_MAX_ENTRIES = 128;
	localparam int MAX_CAPACITY    = 4096;
	localparam int HANDLE_BITS     = 32;
	localparam int CAP_W           = $clog2(MAX_CAPACITY + 1);
	localparam int ACC_W           = ((SIZE_W > CAP_W) ? SIZE_W : CAP_W) + 1;
	localparam int HANDLE_KEEP_W   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

	// Depth of the request queue between front and back
	localparam int CMDQ_DEPTH = 2;

	// Operation codes on the input stream
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESIZE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_CAP_HIGH  = 2'd3
	} status_t;

	// Request kinds after classification in the front
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ADD,
		OP_GET,
		OP_GET_BAD,
		OP_RESIZE,
		OP_CLEAR,
		OP_RESIZE_BAD
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

	typedef struct packed {
		op_t                      op;
		logic [SIZE_W-1:0]        esize;
		logic [HANDLE_KEEP_W-1:0] handle;
		logic [IDX_W-1:0]         index;
		logic [CAP_W-1:0]         ncap;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
		logic [EVICT_W-1:0]  evicted;
		logic [COUNT_W-1:0]  count;
		logic [BYTES_W-1:0]  bytes;
	} res_t;

endpackage

`default_nettype wire

/* sv/hpack_dynamic_table.sv */
// HPACK dynamic header table: add, get and resize requests in, one result per request out.
// The back end takes a request only when idle and finishes it in its run state, retiring the
// oldest entries one a cycle through the registered read port of the entry memories.
// A stalled result output holds the back end, and then the request queue fills and stalls.
// Reset clears counts, pointers and queue, and restores the byte capacity to its maximum.
// The entry memories are not cleared; data read from slots without live entries is never used.
`default_nettype none

module hpack_dynamic_table #(
	parameter int MAX_ENTRIES = hpd_pkg::DEF_MAX_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata, from bit 0: entry_size, entry_handle, entry_index, new_capacity, zero padding
	input  logic [hpd_pkg::IN_DATA_W-1:0]    s_tdata,
	// tuser: func
	input  logic [hpd_pkg::IN_USER_W-1:0]    s_tuser,
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata, from bit 0: out_handle, out_size, evicted, entry_count, bytes_used, zero padding
	output logic [hpd_pkg::OUT_DATA_W-1:0]   m_tdata,
	// tuser: status
	output logic [hpd_pkg::OUT_USER_W-1:0]   m_tuser
);
	import hpd_pkg::*;

	localparam int OFS_HANDLE = SIZE_W;
	localparam int OFS_INDEX  = OFS_HANDLE + HANDLE_W;
	localparam int OFS_NCAP   = OFS_INDEX + IDX_W;

	logic  cq_valid;
	logic  cq_ready;
	cmd_t  cq_cmd;
	res_t  res;

	// Front: classify each request and hold it until the back end is free
	hpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.func         (s_tuser[FUNC_W-1:0]),
		.entry_size   (s_tdata[SIZE_W-1:0]),
		.entry_handle (s_tdata[OFS_HANDLE +: HANDLE_W]),
		.entry_index  (s_tdata[OFS_INDEX +: IDX_W]),
		.new_capacity (s_tdata[OFS_NCAP +: NCAP_W]),
		.cq_valid     (cq_valid),
		.cq_ready     (cq_ready),
		.cq_cmd       (cq_cmd)
	);

	// Back: evict, store and look up; the result register parts it from the output side
	hpd_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_valid  (cq_valid),
		.cq_ready  (cq_ready),
		.cq_cmd    (cq_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result, lowest field first, zero-filled to whole bytes
	assign m_tdata = OUT_DATA_W'({res.bytes, res.count, res.evicted, res.size, res.handle});
	assign m_tuser = res.status;

endmodule

`default_nettype wire

/* sv/hpd_front.sv */
// Front end: classifies incoming requests and holds them in a short queue.
// Depends on hpd_pkg.
`default_nettype none

module hpd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hpd_pkg::FUNC_W-1:0]  func,
	input  logic [hpd_pkg::SIZE_W-1:0]  entry_size,
	input  logic [hpd_pkg::HANDLE_W-1:0] entry_handle,
	input  logic [hpd_pkg::IDX_W-1:0]   entry_index,
	input  logic [hpd_pkg::NCAP_W-1:0]  new_capacity,
	output logic                        cq_valid,
	input  logic                        cq_ready,
	output hpd_pkg::cmd_t               cq_cmd
);
	import hpd_pkg::*;

	localparam int QP_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t            dec_cmd;
	cmd_t            q_mem [CMDQ_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] fill_q;
	logic            push;
	logic            pop;

	always_comb begin
		dec_cmd.esize  = entry_size;
		dec_cmd.handle = entry_handle[HANDLE_KEEP_W-1:0];
		dec_cmd.index  = entry_index;
		dec_cmd.ncap   = CAP_W'(new_capacity);
		case (func)
			FUNC_ADD: begin
				dec_cmd.op = OP_ADD;
			end
			FUNC_GET: begin
				dec_cmd.op = (entry_index == '0) ? OP_GET_BAD : OP_GET;
			end
			FUNC_RESIZE: begin
				if (32'(new_capacity) > 32'(MAX_CAPACITY))
					dec_cmd.op = OP_RESIZE_BAD;
				else if (new_capacity == '0)
					dec_cmd.op = OP_CLEAR;
				else
					dec_cmd.op = OP_RESIZE;
			end
			default: begin
				dec_cmd.op = OP_NOP;
			end
		endcase
	end

	assign in_ready = (fill_q != QC_W'(CMDQ_DEPTH));
	assign cq_valid = (fill_q != '0);
	assign cq_cmd   = q_mem[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = cq_valid && cq_ready;

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= dec_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* sv/hpd_back.sv */
// Back end: ring of entries in two memories, eviction sequencer and result register.
// Depends on hpd_pkg.
`default_nettype none

module hpd_back #(
	parameter int MAX_ENTRIES = hpd_pkg::DEF_MAX_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cq_valid,
	output logic          cq_ready,
	input  hpd_pkg::cmd_t cq_cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output hpd_pkg::res_t res
);
	import hpd_pkg::*;

	localparam int PTR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int IW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam logic [SUM_W-1:0] N_S = SUM_W'(MAX_ENTRIES);

	function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = (v >= N_S) ? v - N_S : v;
		return r[PTR_W-1:0];
	endfunction

	logic [SIZE_W-1:0]        size_mem   [MAX_ENTRIES];
	logic [HANDLE_KEEP_W-1:0] handle_mem [MAX_ENTRIES];

	bk_state_t                state_q, state_d;
	cmd_t                     cmd_q;
	logic [CNT_W-1:0]         count_q;
	logic [CAP_W-1:0]         used_q;
	logic [CAP_W-1:0]         cap_q;
	logic [PTR_W-1:0]         oldest_q;
	logic [CNT_W-1:0]         evict_q;
	logic [SIZE_W-1:0]        rd_size_q;
	logic [HANDLE_KEEP_W-1:0] rd_handle_q;
	logic                     out_valid_q;
	res_t                     out_res_q;

	logic             out_free;
	logic [SUM_W-1:0] head_sum;
	logic [PTR_W-1:0] new_slot;
	logic [PTR_W-1:0] get_slot;
	logic [PTR_W-1:0] oldest_nxt;
	logic             need_room;
	logic             over_cap;
	logic             too_big;
	logic             get_bad;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic             drop;
	logic             finish;
	logic             wr_en;
	logic             clear;
	res_t             res_d;

	assign out_free   = !out_valid_q || res_ready;
	assign head_sum   = SUM_W'(oldest_q) + SUM_W'(count_q);
	assign new_slot   = wrap_slot(head_sum);
	assign get_slot   = wrap_slot(head_sum - SUM_W'(cq_cmd.index));
	assign oldest_nxt = (oldest_q == PTR_W'(MAX_ENTRIES - 1)) ? '0 : oldest_q + 1'b1;
	assign too_big    = ACC_W'(cmd_q.esize) > ACC_W'(cap_q);
	assign need_room  = (count_q != '0) &&
		((ACC_W'(used_q) + ACC_W'(cmd_q.esize) > ACC_W'(cap_q)) ||
		 (count_q >= CNT_W'(MAX_ENTRIES)));
	assign over_cap   = (count_q != '0) && (used_q > cap_q);
	assign get_bad    = IW'(cmd_q.index) > IW'(count_q);

	always_comb begin
		state_d      = state_q;
		cq_ready     = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = oldest_q;
		drop         = 1'b0;
		finish       = 1'b0;
		wr_en        = 1'b0;
		clear        = 1'b0;
		res_d.status = ST_OK;
		res_d.handle = '0;
		res_d.size   = '0;
		case (state_q)
			BK_IDLE: begin
				if (cq_cmd.op == OP_GET)
					rd_addr = get_slot;
				if (cq_valid) begin
					cq_ready = 1'b1;
					rd_en    = 1'b1;
					state_d  = BK_RUN;
				end
			end
			BK_RUN: begin
				case (cmd_q.op)
					OP_ADD: begin
						if (too_big) begin
							finish       = out_free;
							clear        = 1'b1;
							res_d.status = ST_TOO_LARGE;
						end else if (need_room) begin
							drop = 1'b1;
						end else begin
							finish = out_free;
							wr_en  = out_free;
						end
					end
					OP_RESIZE: begin
						if (over_cap)
							drop = 1'b1;
						else
							finish = out_free;
					end
					OP_CLEAR: begin
						finish = out_free;
						clear  = 1'b1;
					end
					OP_GET: begin
						finish = out_free;
						if (get_bad) begin
							res_d.status = ST_BAD_INDEX;
						end else begin
							res_d.handle = HANDLE_W'(rd_handle_q);
							res_d.size   = rd_size_q;
						end
					end
					OP_GET_BAD: begin
						finish       = out_free;
						res_d.status = ST_BAD_INDEX;
					end
					OP_RESIZE_BAD: begin
						finish       = out_free;
						res_d.status = ST_CAP_HIGH;
					end
					default: begin
						finish = out_free;
					end
				endcase
				if (drop) begin
					rd_en   = 1'b1;
					rd_addr = oldest_nxt;
				end
				if (finish)
					state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		// Figures seen after the operation completes
		if (clear) begin
			res_d.evicted = EVICT_W'(count_q);
			res_d.count   = '0;
			res_d.bytes   = '0;
		end else if (cmd_q.op == OP_ADD) begin
			res_d.evicted = EVICT_W'(evict_q);
			res_d.count   = COUNT_W'(count_q + 1'b1);
			res_d.bytes   = BYTES_W'(used_q + CAP_W'(cmd_q.esize));
		end else begin
			res_d.evicted = EVICT_W'(evict_q);
			res_d.count   = COUNT_W'(count_q);
			res_d.bytes   = BYTES_W'(used_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			size_mem[new_slot]   <= cmd_q.esize;
			handle_mem[new_slot] <= cmd_q.handle;
		end
		if (rd_en) begin
			rd_size_q   <= size_mem[rd_addr];
			rd_handle_q <= handle_mem[rd_addr];
		end
		if (cq_ready)
			cmd_q <= cq_cmd;
		if (finish)
			out_res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			used_q      <= '0;
			cap_q       <= CAP_W'(MAX_CAPACITY);
			oldest_q    <= '0;
			evict_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cq_ready) begin
				evict_q <= '0;
				if (cq_cmd.op == OP_RESIZE || cq_cmd.op == OP_CLEAR)
					cap_q <= cq_cmd.ncap;
			end
			if (drop) begin
				used_q   <= used_q - CAP_W'(rd_size_q);
				oldest_q <= oldest_nxt;
				count_q  <= count_q - 1'b1;
				evict_q  <= evict_q + 1'b1;
			end
			if (finish && clear) begin
				count_q  <= '0;
				used_q   <= '0;
				oldest_q <= '0;
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
				used_q  <= used_q + CAP_W'(cmd_q.esize);
			end
			if (finish)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_res_q;

endmodule

`default_nettype wire
